// ===== rtl/dqe_pkg.sv =====
package dqe_pkg;

    localparam int MAX_LABEL   = 63;
    localparam int LABEL_DEPTH = 63;
    localparam int LABEL_AW    = $clog2(LABEL_DEPTH + 1);
    localparam int HDR_BYTES   = 12;
    localparam int HDR_IW      = $clog2(HDR_BYTES);
    localparam int COUNT_W     = 10;
    localparam int CFG_DW      = 48;
    localparam int CFG_IW      = 3;

    localparam logic [7:0]         DOT_CHAR  = 8'd46;
    localparam logic [7:0]         END_CHAR  = 8'd0;
    localparam logic [15:0]        CLASS_IN  = 16'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // request commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_TAIL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_QUERY_ID       = 3'd0;
    localparam logic [CFG_IW-1:0] REG_QR_BIT         = 3'd1;
    localparam logic [CFG_IW-1:0] REG_OPCODE         = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FLAG_BITS      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_Z_BITS         = 3'd4;
    localparam logic [CFG_IW-1:0] REG_RCODE          = 3'd5;
    localparam logic [CFG_IW-1:0] REG_QUESTION_COUNT = 3'd6;
    localparam logic [CFG_IW-1:0] REG_OTHER_COUNTS   = 3'd7;

    // byte sources of the datapath
    localparam logic [2:0] SRC_HDR  = 3'd0;
    localparam logic [2:0] SRC_LEN  = 3'd1;
    localparam logic [2:0] SRC_RAM  = 3'd2;
    localparam logic [2:0] SRC_ZERO = 3'd3;
    localparam logic [2:0] SRC_QHI  = 3'd4;
    localparam logic [2:0] SRC_QLO  = 3'd5;
    localparam logic [2:0] SRC_ONE  = 3'd6;

    // sequencing after a step
    localparam logic [1:0] SEQ_NEXT = 2'd0;
    localparam logic [1:0] SEQ_END  = 2'd1;
    localparam logic [1:0] SEQ_LOOP = 2'd2;
    localparam logic [1:0] SEQ_LEN0 = 2'd3;

    // program entry points
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_HDR   = 3'd0;
    localparam logic [PC_W-1:0] PC_FLUSH = 3'd1;
    localparam logic [PC_W-1:0] PC_LABEL = 3'd2;
    localparam logic [PC_W-1:0] PC_TAIL  = 3'd3;

    typedef struct packed {
        logic [2:0] src;
        logic [1:0] seq;
        logic       clr_len;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        begin
            uc = '{src: SRC_ZERO, seq: SEQ_END, clr_len: 1'b0};
            case (pc)
                3'd0: uc = '{src: SRC_HDR,  seq: SEQ_LOOP, clr_len: 1'b0};
                3'd1: uc = '{src: SRC_LEN,  seq: SEQ_LEN0, clr_len: 1'b1};
                3'd2: uc = '{src: SRC_RAM,  seq: SEQ_LOOP, clr_len: 1'b1};
                3'd3: uc = '{src: SRC_ZERO, seq: SEQ_NEXT, clr_len: 1'b0};
                3'd4: uc = '{src: SRC_QHI,  seq: SEQ_NEXT, clr_len: 1'b0};
                3'd5: uc = '{src: SRC_QLO,  seq: SEQ_NEXT, clr_len: 1'b0};
                3'd6: uc = '{src: SRC_ZERO, seq: SEQ_NEXT, clr_len: 1'b0};
                3'd7: uc = '{src: SRC_ONE,  seq: SEQ_END,  clr_len: 1'b0};
                default: uc = '{src: SRC_ZERO, seq: SEQ_END, clr_len: 1'b0};
            endcase
            return uc;
        end
    endfunction

endpackage

// ===== rtl/dns_query_message_encoder_top.sv =====
// DNS query encoder: turns start, name-character and tail requests into the byte stream
// of a DNS query message, one byte per result. A small microcode program in a ROM steps
// a byte datapath: header (12 bytes), label flush (length byte then the buffered label
// from a 63-byte RAM) and tail (root zero, qtype, class IN). The sequencer emits one
// byte per cycle while the output register is free. A start request runs the header
// program, a dot or a name end after a label runs the label flush, a tail runs the tail
// program; a plain name character or an empty name end runs none. s_ready is low while
// the program runs. Configuration writes must land while no request is in flight.
module dns_query_message_encoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [dqe_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [dqe_pkg::CFG_DW-1:0]    cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [7:0]                    s_name_char,
    input  logic [15:0]                   s_qtype,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_last_of_run,
    output logic                          m_label_error,
    output logic [dqe_pkg::COUNT_W-1:0]   m_msg_len
);

    localparam int AW = dqe_pkg::LABEL_AW;
    localparam int CW = dqe_pkg::COUNT_W;

    // configuration registers
    logic [15:0] query_id_reg;
    logic        qr_bit_reg;
    logic [3:0]  opcode_reg;
    logic [3:0]  flag_bits_reg;
    logic [2:0]  z_bits_reg;
    logic [3:0]  rcode_reg;
    logic [15:0] question_count_reg;
    logic [47:0] other_counts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_id_reg       <= '0;
            qr_bit_reg         <= 1'b0;
            opcode_reg         <= '0;
            flag_bits_reg      <= '0;
            z_bits_reg         <= '0;
            rcode_reg          <= '0;
            question_count_reg <= 16'd1;
            other_counts_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dqe_pkg::REG_QUERY_ID:       query_id_reg       <= cfg_data[15:0];
                dqe_pkg::REG_QR_BIT:         qr_bit_reg         <= cfg_data[0];
                dqe_pkg::REG_OPCODE:         opcode_reg         <= cfg_data[3:0];
                dqe_pkg::REG_FLAG_BITS:      flag_bits_reg      <= cfg_data[3:0];
                dqe_pkg::REG_Z_BITS:         z_bits_reg         <= cfg_data[2:0];
                dqe_pkg::REG_RCODE:          rcode_reg          <= cfg_data[3:0];
                dqe_pkg::REG_QUESTION_COUNT: question_count_reg <= cfg_data[15:0];
                dqe_pkg::REG_OTHER_COUNTS:   other_counts_reg   <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // sequencer and state
    logic                         busy_reg, busy_next;
    logic [dqe_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                label_len_reg, label_len_next;
    logic [CW-1:0]                byte_count_reg, byte_count_next;
    logic                         overflow_reg, overflow_next;
    logic [15:0]                  qtype_reg;

    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_byte_reg, m_byte_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_err_reg, m_err_next;
    logic [CW-1:0]                m_len_reg, m_len_next;

    logic                         accept;
    logic                         step_go;
    dqe_pkg::ucode_t              uc;
    logic [95:0]                  hdr_vec;
    logic [15:0]                  flags;
    logic [dqe_pkg::HDR_IW-1:0]   hdr_sel;
    logic [7:0]                   hdr_byte;
    logic [7:0]                   ram_rd_data;
    logic                         ram_we;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic                         idx_done;
    logic                         finish;
    logic [7:0]                   byte_val;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && !busy_reg;
    assign step_go = busy_reg && (!m_valid_reg || m_ready);
    assign uc      = dqe_pkg::ucode_rom(pc_reg);

    assign flags   = {qr_bit_reg, opcode_reg, flag_bits_reg, z_bits_reg, rcode_reg};
    assign hdr_vec = {query_id_reg, flags, question_count_reg, other_counts_reg};
    // header byte 0 sits in the top byte of the vector
    assign hdr_sel  = dqe_pkg::HDR_IW'(dqe_pkg::HDR_BYTES - 1) - idx_reg[dqe_pkg::HDR_IW-1:0];
    assign hdr_byte = hdr_vec[{hdr_sel, 3'b000} +: 8];

    always_comb begin
        case (uc.src)
            dqe_pkg::SRC_HDR:  byte_val = hdr_byte;
            dqe_pkg::SRC_LEN:  byte_val = 8'(label_len_reg);
            dqe_pkg::SRC_RAM:  byte_val = ram_rd_data;
            dqe_pkg::SRC_QHI:  byte_val = qtype_reg[15:8];
            dqe_pkg::SRC_QLO:  byte_val = qtype_reg[7:0];
            dqe_pkg::SRC_ONE:  byte_val = dqe_pkg::CLASS_IN[7:0];
            default:           byte_val = 8'd0;
        endcase
    end

    always_comb begin
        if (uc.src == dqe_pkg::SRC_HDR) begin
            idx_done = (idx_reg == AW'(dqe_pkg::HDR_BYTES - 1));
        end else begin
            idx_done = (idx_reg == label_len_reg - AW'(1));
        end
    end

    always_comb begin
        case (uc.seq)
            dqe_pkg::SEQ_END:  finish = 1'b1;
            dqe_pkg::SEQ_LOOP: finish = idx_done;
            dqe_pkg::SEQ_LEN0: finish = (label_len_reg == '0);
            default:           finish = 1'b0;
        endcase
    end

    // label buffer write on a plain character, reads run one step ahead of the emit
    assign ram_we = accept && (s_cmd == dqe_pkg::CMD_CHAR) &&
                    (s_name_char != dqe_pkg::DOT_CHAR) && (s_name_char != dqe_pkg::END_CHAR) &&
                    (label_len_reg < AW'(dqe_pkg::MAX_LABEL));
    assign ram_re = step_go && !finish &&
                    ((uc.src == dqe_pkg::SRC_LEN) || (uc.src == dqe_pkg::SRC_RAM));
    assign ram_raddr = (uc.src == dqe_pkg::SRC_RAM) ? idx_reg + AW'(1) : '0;

    dqe_ram #(
        .WIDTH (8),
        .DEPTH (dqe_pkg::LABEL_DEPTH)
    ) u_label_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (label_len_reg),
        .wr_data (s_name_char),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        busy_next       = busy_reg;
        pc_next         = pc_reg;
        idx_next        = idx_reg;
        label_len_next  = label_len_reg;
        byte_count_next = byte_count_reg;
        overflow_next   = overflow_reg;
        m_valid_next    = m_valid_reg;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        m_err_next      = m_err_reg;
        m_len_next      = m_len_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            idx_next = '0;
            case (s_cmd)
                dqe_pkg::CMD_START: begin
                    label_len_next  = '0;
                    byte_count_next = '0;
                    overflow_next   = 1'b0;
                    busy_next       = 1'b1;
                    pc_next         = dqe_pkg::PC_HDR;
                end
                dqe_pkg::CMD_CHAR: begin
                    if (s_name_char == dqe_pkg::DOT_CHAR ||
                        (s_name_char == dqe_pkg::END_CHAR && label_len_reg != '0)) begin
                        busy_next = 1'b1;
                        pc_next   = dqe_pkg::PC_FLUSH;
                    end else if (s_name_char == dqe_pkg::END_CHAR) begin
                        busy_next = 1'b0;
                    end else if (label_len_reg < AW'(dqe_pkg::MAX_LABEL)) begin
                        label_len_next = label_len_reg + AW'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                end
                dqe_pkg::CMD_TAIL: begin
                    label_len_next = '0;
                    busy_next      = 1'b1;
                    pc_next        = dqe_pkg::PC_TAIL;
                end
                default: ;
            endcase
        end

        if (step_go) begin
            if (byte_count_reg != dqe_pkg::COUNT_MAX) begin
                byte_count_next = byte_count_reg + CW'(1);
            end else begin
                byte_count_next = byte_count_reg;
            end
            m_valid_next = 1'b1;
            m_byte_next  = byte_val;
            m_last_next  = finish;
            m_err_next   = overflow_reg;
            m_len_next   = byte_count_next;

            if (finish) begin
                busy_next = 1'b0;
                if (uc.clr_len) begin
                    label_len_next = '0;
                end
            end else begin
                case (uc.seq)
                    dqe_pkg::SEQ_LOOP: idx_next = idx_reg + AW'(1);
                    dqe_pkg::SEQ_LEN0: pc_next  = dqe_pkg::PC_LABEL;
                    default:           pc_next  = pc_reg + dqe_pkg::PC_W'(1);
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            pc_reg         <= '0;
            idx_reg        <= '0;
            label_len_reg  <= '0;
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            pc_reg         <= pc_next;
            idx_reg        <= idx_next;
            label_len_reg  <= label_len_next;
            byte_count_reg <= byte_count_next;
            overflow_reg   <= overflow_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            qtype_reg <= s_qtype;
        end
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_err_reg  <= m_err_next;
        m_len_reg  <= m_len_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;
    assign m_label_error = m_err_reg;
    assign m_msg_len     = m_len_reg;

endmodule

// ===== rtl/dqe_ram.sv =====
module dqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
